// ----- hdl/hfm_pkg.sv -----
// Shared types, constants and the reciprocal table of the 3x3 hole filler.
package hfm_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int SUM_W       = 11;
  localparam int NUM_W       = 4;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 15;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int SLOT_W      = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_ACC,
    S_DIV,
    S_OUT
  } state_t;

  // ceil(2^15 / n): sum * recip >> 15 equals sum / n for sums up to 8 * 255
  function automatic logic [RECIP_W-1:0] recip(input logic [NUM_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10923;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6554;
      4'd6:    r = 16'd5462;
      4'd7:    r = 16'd4682;
      4'd8:    r = 16'd4096;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/hfm_intf.sv -----
// Stream and configuration channel interfaces of the 3x3 hole filler.
interface hfm_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [hfm_pkg::CH_W-1:0] in_red;
  logic [hfm_pkg::CH_W-1:0] in_green;
  logic [hfm_pkg::CH_W-1:0] in_blue;
  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface hfm_res_if;
  logic                     valid;
  logic                     ready;
  logic [hfm_pkg::CH_W-1:0] out_red;
  logic [hfm_pkg::CH_W-1:0] out_green;
  logic [hfm_pkg::CH_W-1:0] out_blue;
  logic                     frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface hfm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hfm_pkg::CFG_IDX_W-1:0] index;
  logic [hfm_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/hole_fill_3x3_mean_core.sv -----
// Streaming 3x3 hole filler: black pixels take the mean of their non-black neighbours.
// Steps: a beat that raises a result runs S_RD, S_ACC, S_DIV and S_OUT; S_OUT holds while
//   the output register is still held. A beat that raises no result stays in S_IDLE.
// Input: one beat a cycle while no result is raised; else no beat is taken until the result,
//   from nine window reads on one RAM port plus one multiply per channel, is loaded.
// Reset: synchronous, active low; clears positions, pending count, output valid; 1024x1024.
module hole_fill_3x3_mean_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic clk,
  input  logic rst_n,
  hfm_cfg_if.sink   cfg_chan,
  hfm_pix_if.sink   in_chan,
  hfm_res_if.source out_chan
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int WDW      = $clog2(MAX_WIDTH + 1);
  localparam int RW       = $clog2(MAX_HEIGHT + 1);
  localparam int PW       = $clog2(MAX_WIDTH + 2);
  localparam int AW       = CW + hfm_pkg::SLOT_W;
  localparam int RAM_DEPTH = 1 << AW;
  localparam int CH_W     = hfm_pkg::CH_W;
  localparam int PIX_W    = hfm_pkg::PIX_W;
  localparam int SUM_W    = hfm_pkg::SUM_W;
  localparam int NUM_W    = hfm_pkg::NUM_W;
  localparam int PROD_W   = SUM_W + hfm_pkg::RECIP_W;
  localparam int SW       = hfm_pkg::SLOT_W;

  // Configuration registers and their clamped views
  logic [hfm_pkg::CFG_W-1:0] cfg_w_r, cfg_w_nxt;
  logic [hfm_pkg::CFG_W-1:0] cfg_h_r, cfg_h_nxt;
  logic [WDW-1:0] w_eff, w_m1;
  logic [RW-1:0]  h_eff, h_m1;

  // Stream positions
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SW-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PW-1:0] pend_r, pend_nxt;

  // Sequencer
  hfm_pkg::state_t state_r, state_nxt;
  logic [1:0] kr_r, kr_nxt, kc_r, kc_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  logic       rd_in_r, rd_in_nxt;
  logic       rd_ctr_r, rd_ctr_nxt;
  logic [1:0] ch_r, ch_nxt;

  // Window accumulation and result
  logic [SUM_W-1:0] acc_r [3];
  logic [SUM_W-1:0] acc_nxt [3];
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [PIX_W-1:0] centre_r, centre_nxt;
  logic [PIX_W-1:0] res_r, res_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_end_r, out_end_nxt;

  // Row store port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  logic             in_acc, cfg_acc, out_take;
  logic             in_last_col, out_last_col, flush_cond, emit;
  logic             rd_inside;
  logic [SW-1:0]    rd_slot;
  logic [CW-1:0]    rd_col;
  logic [PIX_W-1:0] rd_pix;
  logic [SUM_W-1:0] div_sum;
  logic [PROD_W-1:0] prod;
  logic [CH_W-1:0]  quot;

  // Clamp dimensions: zero acts as one, above the maximum as the maximum
  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = WDW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = WDW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_eff = RW'(1);
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg_h_r);
    end
    w_m1 = w_eff - WDW'(1);
    h_m1 = h_eff - RW'(1);
  end

  assign cfg_acc  = cfg_chan.valid && cfg_chan.ready;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_take = out_valid_r && out_chan.ready;

  assign cfg_chan.ready     = 1'b1;
  assign in_chan.ready      = (state_r == hfm_pkg::S_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_red   = out_pix_r[3*CH_W-1:2*CH_W];
  assign out_chan.out_green = out_pix_r[2*CH_W-1:CH_W];
  assign out_chan.out_blue  = out_pix_r[CH_W-1:0];
  assign out_chan.frame_end = out_end_r;

  assign in_last_col  = (WDW'(in_col_r) == w_m1);
  assign out_last_col = (WDW'(out_col_r) == w_m1);
  assign flush_cond   = (in_row_r == '0) && (in_col_r == '0) && (pend_r != '0);

  // Window tap address: row slot out_slot + kr - 1, column out_col + kc - 1
  assign rd_slot   = out_slot_r + SW'(kr_r) + SW'(3);
  assign rd_col    = out_col_r + CW'(kc_r) - CW'(1);
  assign ram_raddr = {rd_slot, rd_col};
  assign rd_inside = (kr_r != 2'd0 || out_row_r != '0) &&
                     (kr_r != 2'd2 || out_row_r != h_m1) &&
                     (kc_r != 2'd0 || out_col_r != '0) &&
                     (kc_r != 2'd2 || !out_last_col);

  assign ram_waddr = {in_slot_r, in_col_r};
  assign ram_wdata = {in_chan.in_red, in_chan.in_green, in_chan.in_blue};

  // Taps outside the frame read as black
  assign rd_pix = rd_in_r ? ram_rdata : '0;

  // Mean by reciprocal multiplication, one channel a cycle while no register write holds the sequencer
  always_comb begin
    case (ch_r)
      2'd0:    div_sum = acc_r[0];
      2'd1:    div_sum = acc_r[1];
      2'd2:    div_sum = acc_r[2];
      default: div_sum = '0;
    endcase
    prod = PROD_W'(div_sum) * PROD_W'(hfm_pkg::recip(num_r));
    quot = prod[hfm_pkg::RECIP_SHIFT +: CH_W];
  end

  always_comb begin
    cfg_w_nxt     = cfg_w_r;
    cfg_h_nxt     = cfg_h_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    in_slot_nxt   = in_slot_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_slot_nxt  = out_slot_r;
    pend_nxt      = pend_r;
    state_nxt     = state_r;
    kr_nxt        = kr_r;
    kc_nxt        = kc_r;
    rd_pend_nxt   = 1'b0;
    rd_in_nxt     = rd_in_r;
    rd_ctr_nxt    = rd_ctr_r;
    ch_nxt        = ch_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    centre_nxt    = centre_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_end_nxt   = out_end_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    emit          = 1'b0;

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    // Fold in the tap read in the previous cycle
    if (rd_pend_r) begin
      if (rd_ctr_r) begin
        centre_nxt = rd_pix;
      end else if (rd_pix != '0) begin
        acc_nxt[0] = acc_r[0] + SUM_W'(rd_pix[3*CH_W-1:2*CH_W]);
        acc_nxt[1] = acc_r[1] + SUM_W'(rd_pix[2*CH_W-1:CH_W]);
        acc_nxt[2] = acc_r[2] + SUM_W'(rd_pix[CH_W-1:0]);
        num_nxt    = num_r + NUM_W'(1);
      end
    end

    if (cfg_acc) begin
      // Any register write restarts the stream; pending pixels are dropped
      case (hfm_pkg::reg_idx_t'(cfg_chan.index))
        hfm_pkg::REG_FRAME_WIDTH:  cfg_w_nxt = cfg_chan.data;
        hfm_pkg::REG_FRAME_HEIGHT: cfg_h_nxt = cfg_chan.data;
        default: ;
      endcase
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      pend_nxt     = '0;
    end else begin
      case (state_r)
        hfm_pkg::S_IDLE: begin
          if (in_acc) begin
            if (in_chan.cmd == hfm_pkg::CMD_PIXEL) begin
              ram_we = 1'b1;
              if (in_last_col) begin
                in_col_nxt  = '0;
                in_slot_nxt = in_slot_r + SW'(1);
                in_row_nxt  = (in_row_r == h_m1) ? '0 : in_row_r + RW'(1);
              end else begin
                in_col_nxt = in_col_r + CW'(1);
              end
              if (pend_r >= PW'(w_eff) + PW'(1)) begin
                emit = 1'b1;
              end else begin
                pend_nxt = pend_r + PW'(1);
              end
            end else if (flush_cond) begin
              emit     = 1'b1;
              pend_nxt = pend_r - PW'(1);
            end
          end
          if (emit) begin
            state_nxt  = hfm_pkg::S_RD;
            kr_nxt     = 2'd0;
            kc_nxt     = 2'd0;
            acc_nxt[0] = '0;
            acc_nxt[1] = '0;
            acc_nxt[2] = '0;
            num_nxt    = '0;
          end
        end

        hfm_pkg::S_RD: begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_in_nxt   = rd_inside;
          rd_ctr_nxt  = (kr_r == 2'd1) && (kc_r == 2'd1);
          if (kc_r == 2'd2) begin
            kc_nxt = 2'd0;
            kr_nxt = kr_r + 2'd1;
            if (kr_r == 2'd2) begin
              state_nxt = hfm_pkg::S_ACC;
            end
          end else begin
            kc_nxt = kc_r + 2'd1;
          end
        end

        hfm_pkg::S_ACC: begin
          ch_nxt    = 2'd0;
          state_nxt = hfm_pkg::S_DIV;
        end

        hfm_pkg::S_DIV: begin
          if (centre_r != '0 || num_r == '0) begin
            // Not a hole, or a hole with no usable neighbour: pass the centre
            res_nxt   = centre_r;
            state_nxt = hfm_pkg::S_OUT;
          end else begin
            case (ch_r)
              2'd0:    res_nxt[3*CH_W-1:2*CH_W] = quot;
              2'd1:    res_nxt[2*CH_W-1:CH_W]   = quot;
              default: res_nxt[CH_W-1:0]        = quot;
            endcase
            ch_nxt = ch_r + 2'd1;
            if (ch_r == 2'd2) begin
              state_nxt = hfm_pkg::S_OUT;
            end
          end
        end

        hfm_pkg::S_OUT: begin
          // Hold until the output register is free, then advance the out position
          if (!out_valid_r || out_chan.ready) begin
            out_valid_nxt = 1'b1;
            out_pix_nxt   = res_r;
            out_end_nxt   = (out_row_r == h_m1) && out_last_col;
            if (out_last_col) begin
              out_col_nxt  = '0;
              out_slot_nxt = out_slot_r + SW'(1);
              out_row_nxt  = (out_row_r == h_m1) ? '0 : out_row_r + RW'(1);
            end else begin
              out_col_nxt = out_col_r + CW'(1);
            end
            state_nxt = hfm_pkg::S_IDLE;
          end
        end

        default: state_nxt = hfm_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= hfm_pkg::DIM_RESET;
      cfg_h_r     <= hfm_pkg::DIM_RESET;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
      pend_r      <= '0;
      kr_r        <= '0;
      kc_r        <= '0;
      rd_pend_r   <= 1'b0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_w_r     <= cfg_w_nxt;
      cfg_h_r     <= cfg_h_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_slot_r   <= in_slot_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_slot_r  <= out_slot_nxt;
      pend_r      <= pend_nxt;
      kr_r        <= kr_nxt;
      kc_r        <= kc_nxt;
      rd_pend_r   <= rd_pend_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    rd_in_r   <= rd_in_nxt;
    rd_ctr_r  <= rd_ctr_nxt;
    acc_r     <= acc_nxt;
    num_r     <= num_nxt;
    centre_r  <= centre_nxt;
    res_r     <= res_nxt;
    out_pix_r <= out_pix_nxt;
    out_end_r <= out_end_nxt;
  end

  // Four rotating row slots of 2^CW pixels each
  hfm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RAM_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- hdl/hfm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module hfm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/hfm_checker.sv -----
// Port-level assertions for the 3x3 hole filler and their bind to the top level.
module hfm_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [hfm_pkg::CH_W-1:0] out_red,
  input logic [hfm_pkg::CH_W-1:0] out_green,
  input logic [hfm_pkg::CH_W-1:0] out_blue,
  input logic                     frame_end
);

  // A stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_red, out_green, out_blue, frame_end}))
    else $error("result beat changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result is never raised in the cycle straight after an input beat
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result raised directly after an input beat");

  // Input is not taken while a new result is being produced
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("input ready while the result was being loaded");

endmodule

bind hole_fill_3x3_mean_core hfm_checker u_hfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_red   (out_chan.out_red),
  .out_green (out_chan.out_green),
  .out_blue  (out_chan.out_blue),
  .frame_end (out_chan.frame_end)
);

// ----- sim/hole_fill_3x3_mean_core_tb.sv -----
// Self-checking stream testbench for the 3x3 hole filler, with its own pixel predictor.
module hole_fill_3x3_mean_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W          = hfm_pkg::CH_W;
  localparam int PIX_W         = hfm_pkg::PIX_W;
  localparam int CFG_W         = hfm_pkg::CFG_W;
  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int ROW_SLOTS     = 4;
  // Quiet cycles with no beat on any channel before the run is declared hung.
  localparam int QUIET_LIMIT   = 4000;
  // Wait after the last owed result so the core can finish its last beat and go idle.
  localparam int SETTLE_CYCLES = 32;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } fill_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hfm_cfg_if cfg_bus ();
  hfm_pix_if pix_bus ();
  hfm_res_if res_bus ();

  hole_fill_3x3_mean_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (pix_bus),
    .out_chan (res_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping
  // ---------------------------------------------------------------------------
  pix_item_t    pix_queue[$];      // items waiting for the driver
  fill_result_t filled_due[$];     // filled pixels still owed by the core
  int           beats_queued = 0;
  int           beats_taken  = 0;
  int           error_count  = 0;
  int           results_seen = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         pix_taken = 1'b0;  // pixel beat accepted at the last rising edge

  // ---------------------------------------------------------------------------
  // Predictor state: the register copies, the row slots and both raster positions
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_reg  = hfm_pkg::DIM_RESET;
  logic [CFG_W-1:0] height_reg = hfm_pkg::DIM_RESET;
  logic [PIX_W-1:0] line_mem [ROW_SLOTS*MAX_W];
  int in_col   = 0;
  int in_row   = 0;
  int in_slot  = 0;
  int out_col  = 0;
  int out_row  = 0;
  int out_slot = 0;
  int pending  = 0;

  // Registers hold 11 bits; the core works with them clamped into 1..max.
  function automatic int eff_dim(logic [CFG_W-1:0] v, int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic bit skip(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic restart_stream();
    in_col   = 0;
    in_row   = 0;
    in_slot  = 0;
    out_col  = 0;
    out_row  = 0;
    out_slot = 0;
    pending  = 0;
  endtask

  // Build the window around the next output position, fill a hole from its
  // non-black in-frame neighbours, then advance the output raster position.
  task automatic emit_fill();
    int w, h, r, c, slot, num;
    int sum_r, sum_g, sum_b;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] centre;
    fill_result_t res;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    num = 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    centre = '0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r = out_row + dr;
        c = out_col + dc;
        pix = '0;
        // Skip neighbours outside the frame: they count as black.
        if (r >= 0 && r < h && c >= 0 && c < w) begin
          slot = (out_slot + ROW_SLOTS + dr) % ROW_SLOTS;
          pix = line_mem[slot*MAX_W + c];
        end
        if (dr == 0 && dc == 0) begin
          centre = pix;
        end else if (pix != '0) begin
          sum_r += pix[23:16];
          sum_g += pix[15:8];
          sum_b += pix[7:0];
          num++;
        end
      end
    end
    if (centre == '0 && num != 0) begin
      centre = {CH_W'(sum_r / num), CH_W'(sum_g / num), CH_W'(sum_b / num)};
    end
    res.red       = centre[23:16];
    res.green     = centre[15:8];
    res.blue      = centre[7:0];
    res.frame_end = (out_row == h - 1) && (out_col == w - 1);
    filled_due.insert(filled_due.size(), res);

    out_col++;
    if (out_col >= w) begin
      out_col  = 0;
      out_slot = (out_slot + 1) % ROW_SLOTS;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endtask

  // Store an accepted pixel and emit once the lag of one row plus one pixel is
  // covered; a flush only drains at a frame boundary with something pending.
  task automatic predict_fill(pix_item_t it);
    int w, h;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    if (it.cmd == hfm_pkg::CMD_PIXEL) begin
      line_mem[in_slot*MAX_W + in_col] = {it.red, it.green, it.blue};
      in_col++;
      if (in_col >= w) begin
        in_col  = 0;
        in_slot = (in_slot + 1) % ROW_SLOTS;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      if (pending >= w + 1) begin
        emit_fill();
      end else begin
        pending++;
      end
    end else if (in_row == 0 && in_col == 0 && pending > 0) begin
      emit_fill();
      pending--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor and watchdog: sample every channel at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    fill_result_t want;
    logic any_beat;
    pix_item_t got_item;
    any_beat  = 1'b0;
    pix_taken = 1'b0;
    if (rst_n) begin
      // Compare results before predicting this edge's pixel, so a fresh
      // expectation can never cover a result already on the bus.
      if (res_bus.valid && res_bus.ready) begin
        any_beat = 1'b1;
        results_seen++;
        if (filled_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = filled_due.pop_front();
          if (res_bus.out_red !== want.red)
            report_mismatch($sformatf("result %0d red %0d, want %0d",
                                      results_seen, res_bus.out_red, want.red));
          if (res_bus.out_green !== want.green)
            report_mismatch($sformatf("result %0d green %0d, want %0d",
                                      results_seen, res_bus.out_green, want.green));
          if (res_bus.out_blue !== want.blue)
            report_mismatch($sformatf("result %0d blue %0d, want %0d",
                                      results_seen, res_bus.out_blue, want.blue));
          if (res_bus.frame_end !== want.frame_end)
            report_mismatch($sformatf("result %0d frame_end %b, want %b",
                                      results_seen, res_bus.frame_end, want.frame_end));
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        any_beat = 1'b1;
        case (hfm_pkg::reg_idx_t'(cfg_bus.index))
          hfm_pkg::REG_FRAME_WIDTH:  width_reg  = cfg_bus.data;
          hfm_pkg::REG_FRAME_HEIGHT: height_reg = cfg_bus.data;
          default: ;
        endcase
        // Any register write restarts the stream and drops pending pixels.
        restart_stream();
      end
      if (pix_bus.valid && pix_bus.ready) begin
        any_beat  = 1'b1;
        pix_taken = 1'b1;
        got_item  = {pix_bus.cmd, pix_bus.in_red, pix_bus.in_green, pix_bus.in_blue};
        predict_fill(got_item);
        beats_taken++;
      end
    end
    quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver: hold a beat until taken, otherwise advance or idle
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_pixels
    pix_item_t nxt;
    if (rst_n && !(pix_bus.valid && !pix_taken)) begin
      if (pix_queue.size() != 0 && !skip(send_idle_pct)) begin
        nxt = pix_queue.pop_front();
        pix_bus.valid    <= 1'b1;
        pix_bus.cmd      <= nxt.cmd;
        pix_bus.in_red   <= nxt.red;
        pix_bus.in_green <= nxt.green;
        pix_bus.in_blue  <= nxt.blue;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    res_bus.ready <= !skip(recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 48; recv_idle_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_idle_pct = 48; end
      IDLE_BOTH: begin send_idle_pct = 21; recv_idle_pct = 21; end
      default:   begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  // Write one register; only ever called with the core idle.
  task automatic write_reg(hfm_pkg::reg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_pixel(logic [PIX_W-1:0] pix);
    pix_queue.insert(pix_queue.size(), {hfm_pkg::CMD_PIXEL, pix});
    beats_queued++;
  endtask

  // Payload of a flush is don't-care: randomise it.
  task automatic queue_flush();
    pix_queue.insert(pix_queue.size(), {hfm_pkg::CMD_FLUSH, PIX_W'($urandom)});
    beats_queued++;
  endtask

  // Plenty of holes and saturated channels so the mean path is busy.
  function automatic logic [PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return '0;
    if (pick < 40) return {CH_W'($urandom_range(1) * 255), CH_W'($urandom_range(1) * 255),
                           CH_W'($urandom_range(1) * 255)};
    if (pick < 48) return PIX_W'(CH_W'($urandom)) << (CH_W * $urandom_range(2));
    return PIX_W'($urandom);
  endfunction

  // Mostly whole frames with random content, some cut short, the odd flush
  // mid-frame (ignored), and a random drain after most frames.
  task automatic queue_random_frames(int w, int h, int budget);
    int n, len;
    n = 0;
    while (n < budget) begin
      len = w * h;
      if (len > 1 && skip(10)) len = $urandom_range(len - 1, 1);
      if (len > budget - n) len = budget - n;
      for (int i = 0; i < len; i++) begin
        if (skip(4)) queue_flush();
        queue_pixel(rand_pixel());
      end
      n += len;
      if (skip(60)) repeat ($urandom_range(w + 2, 1)) queue_flush();
    end
  endtask

  // Wait for every queued beat to go in and every owed result to come out,
  // then give the core time to finish any beat that raises no result.
  task automatic settle();
    while (beats_taken != beats_queued || filled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned w_raw, int unsigned h_raw, idle_mode_t mode,
                           int budget);
    write_reg(hfm_pkg::REG_FRAME_WIDTH, w_raw);
    write_reg(hfm_pkg::REG_FRAME_HEIGHT, h_raw);
    set_idle(mode);
    queue_random_frames(eff_dim(CFG_W'(w_raw), MAX_W), eff_dim(CFG_W'(h_raw), MAX_H), budget);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    pix_bus.valid    = 1'b0;
    pix_bus.cmd      = hfm_pkg::CMD_PIXEL;
    pix_bus.in_red   = '0;
    pix_bus.in_green = '0;
    pix_bus.in_blue  = '0;
    res_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = hfm_pkg::REG_FRAME_WIDTH;
    cfg_bus.data     = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed 3x3 frame: corner hole, white and coloured neighbours, a centre
    // hole with mixed neighbours, a hole whose neighbours are all holes, and a
    // flush in mid-frame that must be ignored. Then drain, plus one flush
    // with nothing left pending.
    set_idle(IDLE_NONE);
    write_reg(hfm_pkg::REG_FRAME_WIDTH, 3);
    write_reg(hfm_pkg::REG_FRAME_HEIGHT, 3);
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h000000);
    queue_pixel(24'h010203);
    queue_flush();
    queue_pixel(24'h000000);
    queue_pixel(24'h000000);
    queue_pixel(24'h0000FF);
    queue_pixel(24'h000000);
    queue_pixel(24'h000000);
    repeat (5) queue_flush();
    settle();

    // Random phases over several geometries, clamped ones included.
    run_phase(0, 0, IDLE_SEND, 50);
    run_phase(4, 3, IDLE_RECV, 120);
    run_phase(5, 2047, IDLE_BOTH, 120);
    run_phase(1, 1024, IDLE_NONE, 80);
    run_phase(7, 4, IDLE_SEND, 120);
    run_phase(3, 1, IDLE_RECV, 80);
    run_phase(2, 2, IDLE_BOTH, 80);
    run_phase(6, 3, IDLE_NONE, 100);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
